// ----- rtl/wlom_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlom_pkg
// Shared types, widths and helpers of the windowed latency overload monitor.
// ----------------------------------------------------------------------------
package wlom_pkg;

  localparam int NUM_SERVERS = 16;
  localparam int SRV_W       = $clog2(NUM_SERVERS);
  localparam int WINDOW_MAX  = 16;
  localparam int POS_W       = $clog2(WINDOW_MAX);
  localparam int FILL_W      = POS_W + 1;
  localparam int RESP_W      = 14;
  localparam int TS_W        = 48;
  localparam int SUM_W       = 18;
  localparam int THR_W       = 14;
  localparam int LIMIT_W     = THR_W + FILL_W;
  localparam int RING_DEPTH  = NUM_SERVERS * WINDOW_MAX;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = OUT_PTR_W + 1;
  localparam int CFG_DATA_W  = 14;

  localparam int S_TDATA_W   = 72;
  localparam int M_TDATA_W   = 104;

  localparam logic [RESP_W-1:0] TIMEOUT_MS    = RESP_W'(10000);
  localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(10000);
  localparam logic [FILL_W-1:0] WINDOW_RST    = FILL_W'(1);
  localparam logic [TS_W-1:0]   TS_MAX        = {TS_W{1'b1}};

  typedef enum logic [0:0] {
    CFG_WINDOW_LEN = 1'b0,
    CFG_THRESHOLD  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TS_W-1:0]   start;
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
    logic [POS_W-1:0]  wp;
    logic              ov;
  } srv_state_t;

  localparam int STATE_W = $bits(srv_state_t);

  typedef struct packed {
    logic [TS_W-1:0]  period_end_ms;
    logic [TS_W-1:0]  period_start_ms;
    logic [SRV_W-1:0] report_server;
  } report_t;

  function automatic logic [FILL_W-1:0] eff_window(input logic [FILL_W-1:0] wl);
    logic [FILL_W-1:0] m;
    m = wl;
    if (wl == '0) m = FILL_W'(1);
    else if (wl > FILL_W'(WINDOW_MAX)) m = FILL_W'(WINDOW_MAX);
    return m;
  endfunction

  function automatic logic [RESP_W-1:0] norm_resp(input logic [RESP_W-1:0] resp,
                                                  input logic tmo);
    logic [RESP_W-1:0] r;
    r = resp;
    if (tmo || resp > TIMEOUT_MS) r = TIMEOUT_MS;
    return r;
  endfunction

endpackage

// ----- rtl/wlom_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlom_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wlom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/wlom_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlom_out_fifo
// Small result queue between the update pipeline and the output stream.
// ----------------------------------------------------------------------------
module wlom_out_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  wlom_pkg::report_t           push_data,
  input  logic                        pop,
  output logic                        valid,
  output wlom_pkg::report_t           head,
  output logic [wlom_pkg::OUT_CNT_W-1:0] count
);
  import wlom_pkg::*;

  report_t              store [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 do_pop;

  assign valid  = (count != '0);
  assign head   = store[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      case ({push, do_pop})
        2'b10:   count <= count + OUT_CNT_W'(1);
        2'b01:   count <= count - OUT_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

endmodule

// ----- rtl/windowed_latency_overload_monitor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_latency_overload_monitor_unit
// Per-server moving window of response times with overload period reports.
// ----------------------------------------------------------------------------
// a report passes the stage 1 and stage 2 registers and the result queue to m_tvalid
// throughput: one item per cycle while s_tready is high; state read, ring read and
//   write-back: a three-stage pipeline on two RAMs, forwarding between same servers
// s_tready drops while queued results plus items in flight reach the 4-entry queue
// reset: window_len 1, threshold_ms 10000, per-server state valid bits cleared
//   at once; ring entries are written before their values are used
module windowed_latency_overload_monitor_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // server_index[3:0], timestamp_ms[51:4], response_ms[65:52], zero pad
  input  logic [wlom_pkg::S_TDATA_W-1:0] s_tdata,
  // timed_out[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // report_server[3:0], period_start_ms[51:4], period_end_ms[99:52], zero pad
  output logic [wlom_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  wlom_pkg::cfg_reg_t             cfg_index,
  input  logic [wlom_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wlom_pkg::*;

  // configuration
  logic [FILL_W-1:0]  window_len;
  logic [THR_W-1:0]   threshold_ms;
  logic [FILL_W-1:0]  win_m;
  logic [LIMIT_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len   <= WINDOW_RST;
      threshold_ms <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LEN: window_len   <= cfg_data[FILL_W-1:0];
        CFG_THRESHOLD:  threshold_ms <= cfg_data[THR_W-1:0];
        default:        window_len   <= window_len;
      endcase
    end
  end

  assign win_m = eff_window(window_len);
  assign limit = LIMIT_W'(threshold_ms) * LIMIT_W'(win_m);

  // input unpack
  logic               accept;
  logic [SRV_W-1:0]   in_srv;
  logic [TS_W-1:0]    in_ts;
  logic [RESP_W-1:0]  in_resp;

  assign accept  = s_tvalid && s_tready;
  assign in_srv  = s_tdata[SRV_W-1:0];
  assign in_ts   = s_tdata[SRV_W+TS_W-1:SRV_W];
  assign in_resp = s_tdata[SRV_W+TS_W+RESP_W-1:SRV_W+TS_W];

  // pipeline registers
  logic              v1;
  logic [SRV_W-1:0]  s1_srv;
  logic [TS_W-1:0]   s1_ts;
  logic [RESP_W-1:0] s1_resp;
  logic              s1_vld;

  logic              v2;
  logic [SRV_W-1:0]  s2_srv;
  logic [TS_W-1:0]   s2_ts;
  logic [RESP_W-1:0] s2_resp;
  srv_state_t        s2_st;
  logic [RING_AW-1:0] s2_raddr;

  logic              lw_v;
  logic [SRV_W-1:0]  lw_srv;
  srv_state_t        lw_st;
  logic [RING_AW-1:0] lw_raddr;
  logic [RESP_W-1:0] lw_rdata;

  logic [NUM_SERVERS-1:0] st_valid;

  // memories
  logic [STATE_W-1:0] st_rdata;
  logic [RESP_W-1:0]  ring_rdata;
  logic [RING_AW-1:0] ring_raddr;
  logic [RING_AW-1:0] ring_waddr;
  srv_state_t         st2_next;

  assign ring_waddr = {s2_srv, s2_st.wp};

  wlom_ram #(.WIDTH(STATE_W), .DEPTH(NUM_SERVERS)) u_state_ram (
    .clk   (clk),
    .we    (v2),
    .waddr (s2_srv),
    .wdata (st2_next),
    .re    (accept),
    .raddr (in_srv),
    .rdata (st_rdata)
  );

  wlom_ram #(.WIDTH(RESP_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (v2),
    .waddr (ring_waddr),
    .wdata (s2_resp),
    .re    (v1),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // stage 1: state with forwarding, ring read of the oldest entry
  srv_state_t st1;

  always_comb begin
    if (v2 && s2_srv == s1_srv) begin
      st1 = st2_next;
    end else if (lw_v && lw_srv == s1_srv) begin
      st1 = lw_st;
    end else if (s1_vld) begin
      st1 = srv_state_t'(st_rdata);
    end else begin
      st1 = '0;
    end
  end

  assign ring_raddr = {s1_srv, st1.wp - st1.fill[POS_W-1:0]};

  // stage 2: update window, overload decision
  logic [RESP_W-1:0]  old_resp;
  logic               replace;
  logic [SUM_W-1:0]   sum_base;
  logic [SUM_W-1:0]   sum_new;
  logic               below;
  logic [TS_W:0]      end_sum;
  logic               emit;
  report_t            rep;

  assign old_resp = (lw_v && lw_raddr == s2_raddr) ? lw_rdata : ring_rdata;
  assign replace  = (s2_st.fill >= win_m);
  assign sum_base = replace ? (s2_st.sum - SUM_W'(old_resp)) : s2_st.sum;
  assign sum_new  = sum_base + SUM_W'(s2_resp);
  assign below    = (LIMIT_W'(sum_new) < limit);
  assign end_sum  = {1'b0, s2_ts} + (TS_W+1)'(s2_resp);
  assign emit     = v2 && s2_st.ov && below;

  always_comb begin
    st2_next      = s2_st;
    st2_next.wp   = s2_st.wp + POS_W'(1);
    st2_next.fill = replace ? s2_st.fill : s2_st.fill + FILL_W'(1);
    st2_next.sum  = sum_new;
    if (s2_st.ov) begin
      if (below) st2_next.ov = 1'b0;
    end else if (st2_next.fill == win_m && !below) begin
      st2_next.ov    = 1'b1;
      st2_next.start = s2_ts;
    end
  end

  always_comb begin
    rep.report_server   = s2_srv;
    rep.period_start_ms = s2_st.start;
    rep.period_end_ms   = end_sum[TS_W] ? TS_MAX : end_sum[TS_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      lw_v     <= 1'b0;
      st_valid <= '0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      lw_v <= v2;
      if (v2) st_valid[s2_srv] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_srv  <= in_srv;
      s1_ts   <= in_ts;
      s1_resp <= norm_resp(in_resp, s_tuser);
      s1_vld  <= st_valid[in_srv];
    end
    s2_srv   <= s1_srv;
    s2_ts    <= s1_ts;
    s2_resp  <= s1_resp;
    s2_st    <= st1;
    s2_raddr <= ring_raddr;
    lw_srv   <= s2_srv;
    lw_st    <= st2_next;
    lw_raddr <= ring_waddr;
    lw_rdata <= s2_resp;
  end

  // result queue
  logic [OUT_CNT_W-1:0] q_count;
  logic [OUT_CNT_W:0]   pending;
  report_t              q_head;

  wlom_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (rep),
    .pop       (m_tready),
    .valid     (m_tvalid),
    .head      (q_head),
    .count     (q_count)
  );

  assign pending  = (OUT_CNT_W+1)'(q_count) + (OUT_CNT_W+1)'(v1) + (OUT_CNT_W+1)'(v2);
  assign s_tready = (pending < (OUT_CNT_W+1)'(OUT_DEPTH));
  assign m_tdata  = {{(M_TDATA_W-$bits(report_t)){1'b0}}, q_head};

endmodule

// ----- rtl/wlom_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlom_checker
// Port-level checks of the overload monitor, bound to the top level.
// ----------------------------------------------------------------------------
module wlom_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [wlom_pkg::M_TDATA_W-1:0] m_tdata
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input stalls only with results queued
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> m_tvalid)
    else $error("input stalled without queued results");

  // a new result comes from an accepted item that passed both pipeline stages and the queue
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
    else $error("result without matching item");

endmodule

bind windowed_latency_overload_monitor_unit wlom_checker u_wlom_checker (.*);
